[src/ent_pkg.sv]
// shared types, codes and helpers for the envelope node table
package ent_pkg;

    localparam int MAX_NODES_DEF = 32;

    localparam logic [7:0]  MARK_NONE = 8'hFF;
    localparam logic [6:0]  Y_LIMIT   = 7'd64;
    localparam logic [6:0]  PRESET_Y  = 7'd32;
    localparam logic [15:0] PRESET_X0 = 16'd0;
    localparam logic [15:0] PRESET_X1 = 16'd50;
    localparam logic [15:0] X_MAX     = 16'hFFFF;

    typedef enum logic [2:0] {
        KIND_INSERT     = 3'd0,
        KIND_DELETE     = 3'd1,
        KIND_MOVE       = 3'd2,
        KIND_PRESET     = 3'd3,
        KIND_CLEAR      = 3'd4,
        KIND_READ       = 3'd5,
        KIND_SET_MARKER = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_IGNORED = 2'd2
    } stat_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] node_x;
        logic [7:0]  node_y;
        logic [4:0]  node_index;
        logic [1:0]  marker_select;
        logic [7:0]  marker_value;
    } req_t;

    typedef struct packed {
        stat_t       status;
        logic [4:0]  result_index;
        logic [5:0]  nodes_used;
        logic [15:0] out_x;
        logic [6:0]  out_y;
        logic        enabled;
    } rsp_t;

    typedef struct packed {
        logic [15:0] x;
        logic [6:0]  y;
    } node_t;

    function automatic logic [6:0] clamp_y(input logic [7:0] y);
        clamp_y = (y > {1'b0, Y_LIMIT}) ? Y_LIMIT : y[6:0];
    endfunction

    function automatic rsp_t pack_rsp(input stat_t s, input logic [4:0] ri,
                                      input logic [5:0] nc, input logic [15:0] x,
                                      input logic [6:0] y, input logic en);
        rsp_t r;
        r.status       = s;
        r.result_index = ri;
        r.nodes_used   = nc;
        r.out_x        = x;
        r.out_y        = y;
        r.enabled      = en;
        pack_rsp = r;
    endfunction

endpackage

[src/ent_ram.sv]
// generic single write port, single read port ram with registered read
module ent_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[src/envelope_node_table.sv]
// envelope node table: x-sorted node list with marker indices, one request at a time
// clear, rejected requests and set marker on an empty table are answered straight from idle;
//   read and set marker read one node, preset writes two nodes; move reads the neighbours it has;
//   delete shifts each entry above the index down; insert searches, then shifts entries up
// all table traffic goes through one ram read port and one write port; each shifted entry is read, then written
// busy is high until the strobe cycle, in which the next request can be taken; no result stall
// reset: count 0, markers none, enable low; node storage is not cleared (entries beyond count unused)
module envelope_node_table
    import ent_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t cmd,
    output logic done,
    output rsp_t result
);

    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int AW = $clog2(MAX_NODES);
    localparam int WW = (CW > 5) ? CW : 5;
    localparam int NW = $bits(node_t);

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_SHR_RD,
        S_SHR_WR,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_MOV_RDLO,
        S_MOV_LO,
        S_MOV_RDHI,
        S_MOV_HI,
        S_MOV_WR,
        S_PRE_WR0,
        S_PRE_WR1,
        S_READ_RD,
        S_READ_OUT
    } state_t;

    state_t        state_reg;
    req_t          req_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] ptr_reg;
    logic [CW-1:0] ridx_reg;
    logic [7:0]    markers_reg [4];
    logic          enable_reg;
    logic [15:0]   lo_reg;
    logic [15:0]   hi_reg;
    logic [15:0]   hold_x_reg;
    logic [6:0]    hold_y_reg;
    logic          done_reg;
    rsp_t          result_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    node_t         ram_wdata;
    logic [NW-1:0] ram_rdata;
    node_t         rd_node;

    logic          idx_ok;
    logic [15:0]   mov_lo_x;
    logic [15:0]   mov_x;
    logic [6:0]    req_y;
    logic [CW-1:0] ptr_inc;
    logic [CW-1:0] ptr_dec;
    logic [CW-1:0] req_idx;

    assign rd_node  = ram_rdata;
    assign idx_ok   = WW'(cmd.node_index) < WW'(count_reg);
    assign req_y    = clamp_y(req_reg.node_y);
    assign ptr_inc  = ptr_reg + 1'b1;
    assign ptr_dec  = ptr_reg - 1'b1;
    assign req_idx  = CW'(req_reg.node_index);
    // low bound first, then high bound
    assign mov_lo_x = (req_reg.node_x < lo_reg) ? lo_reg : req_reg.node_x;
    assign mov_x    = (mov_lo_x > hi_reg) ? hi_reg : mov_lo_x;

    ent_ram #(
        .WIDTH (NW),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = AW'(ptr_reg);
        ram_raddr = AW'(ptr_reg);
        ram_wdata = rd_node;
        case (state_reg)
            S_SHR_RD:   ram_raddr = AW'(ptr_dec);
            S_SHR_WR:   ram_we = 1'b1;
            S_INS_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(ridx_reg);
                ram_wdata = '{x: req_reg.node_x, y: req_y};
            end
            S_DEL_RD:   ram_raddr = AW'(ptr_inc);
            S_DEL_WR:   ram_we = 1'b1;
            S_MOV_RDLO: ram_raddr = AW'(ptr_dec);
            S_MOV_RDHI: ram_raddr = AW'(ptr_inc);
            S_MOV_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '{x: mov_x, y: req_y};
            end
            S_PRE_WR0:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{x: PRESET_X0, y: PRESET_Y};
            end
            S_PRE_WR1:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(1);
                ram_wdata = '{x: PRESET_X1, y: PRESET_Y};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            req_reg    <= '0;
            count_reg  <= '0;
            ptr_reg    <= '0;
            ridx_reg   <= '0;
            for (int m = 0; m < 4; m++)
            begin
                markers_reg[m] <= MARK_NONE;
            end
            enable_reg <= 1'b0;
            lo_reg     <= '0;
            hi_reg     <= X_MAX;
            hold_x_reg <= '0;
            hold_y_reg <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg    <= cmd;
                        ridx_reg   <= (cmd.kind == KIND_READ) ? CW'(cmd.node_index) : '0;
                        // insert searches from node 0, set marker reports node 0
                        ptr_reg    <= (cmd.kind == KIND_INSERT || cmd.kind == KIND_SET_MARKER) ?
                                      '0 : CW'(cmd.node_index);
                        lo_reg     <= '0;
                        hi_reg     <= X_MAX;
                        hold_x_reg <= '0;
                        hold_y_reg <= '0;
                        case (cmd.kind)
                            KIND_INSERT:
                            begin
                                if (count_reg >= CW'(MAX_NODES))
                                begin
                                    result_reg <= pack_rsp(ST_FULL, '0, 6'(count_reg),
                                                           '0, '0, enable_reg);
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_INS_RD;
                                end
                            end
                            KIND_DELETE:
                            begin
                                if (count_reg <= CW'(1) || !idx_ok)
                                begin
                                    result_reg <= pack_rsp(ST_IGNORED, cmd.node_index,
                                                           6'(count_reg), '0, '0, enable_reg);
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_DEL_RD;
                                end
                            end
                            KIND_MOVE:
                            begin
                                if (!idx_ok)
                                begin
                                    result_reg <= pack_rsp(ST_IGNORED, cmd.node_index,
                                                           6'(count_reg), '0, '0, enable_reg);
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_MOV_RDLO;
                                end
                            end
                            KIND_PRESET:
                            begin
                                if (count_reg != '0)
                                begin
                                    result_reg <= pack_rsp(ST_IGNORED, '0, 6'(count_reg),
                                                           '0, '0, enable_reg);
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_PRE_WR0;
                                end
                            end
                            KIND_CLEAR:
                            begin
                                count_reg  <= '0;
                                enable_reg <= 1'b0;
                                result_reg <= pack_rsp(ST_DONE, '0, '0, '0, '0, 1'b0);
                                done_reg   <= 1'b1;
                            end
                            KIND_READ:
                            begin
                                if (!idx_ok)
                                begin
                                    result_reg <= pack_rsp(ST_IGNORED, cmd.node_index,
                                                           6'(count_reg), '0, '0, enable_reg);
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_READ_RD;
                                end
                            end
                            KIND_SET_MARKER:
                            begin
                                markers_reg[cmd.marker_select] <= cmd.marker_value;
                                // result reports node 0 when the table has one
                                if (count_reg == '0)
                                begin
                                    result_reg <= pack_rsp(ST_DONE, '0, '0, '0, '0, enable_reg);
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_READ_RD;
                                end
                            end
                            default:
                            begin
                                result_reg <= pack_rsp(ST_IGNORED, '0, 6'(count_reg),
                                                       '0, '0, enable_reg);
                                done_reg   <= 1'b1;
                            end
                        endcase
                    end
                end
                // forward search for the first node with x not below the new x
                S_INS_RD:
                begin
                    if (ptr_reg == count_reg)
                    begin
                        ridx_reg  <= ptr_reg;
                        state_reg <= S_SHR_RD;
                    end
                    else
                    begin
                        state_reg <= S_INS_CMP;
                    end
                end
                S_INS_CMP:
                begin
                    if (rd_node.x < req_reg.node_x)
                    begin
                        ptr_reg   <= ptr_inc;
                        state_reg <= S_INS_RD;
                    end
                    else
                    begin
                        ridx_reg  <= ptr_reg;
                        ptr_reg   <= count_reg;
                        state_reg <= S_SHR_RD;
                    end
                end
                // shift right from the top down to the insert place
                S_SHR_RD:
                begin
                    state_reg <= (ptr_reg == ridx_reg) ? S_INS_WR : S_SHR_WR;
                end
                S_SHR_WR:
                begin
                    ptr_reg   <= ptr_dec;
                    state_reg <= S_SHR_RD;
                end
                S_INS_WR:
                begin
                    count_reg <= count_reg + 1'b1;
                    for (int m = 0; m < 4; m++)
                    begin
                        if (markers_reg[m] != MARK_NONE && markers_reg[m] >= 8'(ridx_reg))
                        begin
                            markers_reg[m] <= markers_reg[m] + 8'd1;
                        end
                    end
                    result_reg <= pack_rsp(ST_DONE, 5'(ridx_reg), 6'(count_reg + 1'b1),
                                           req_reg.node_x, req_y, enable_reg);
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                // shift left from the deleted place up to the top
                S_DEL_RD:
                begin
                    if (ptr_inc == count_reg)
                    begin
                        count_reg <= count_reg - 1'b1;
                        for (int m = 0; m < 4; m++)
                        begin
                            if (markers_reg[m] != MARK_NONE)
                            begin
                                if (markers_reg[m] == 8'(req_reg.node_index))
                                begin
                                    markers_reg[m] <= MARK_NONE;
                                end
                                else if (markers_reg[m] > 8'(req_reg.node_index))
                                begin
                                    markers_reg[m] <= markers_reg[m] - 8'd1;
                                end
                            end
                        end
                        result_reg <= pack_rsp(ST_DONE, req_reg.node_index,
                                               6'(count_reg - 1'b1), hold_x_reg, hold_y_reg,
                                               enable_reg);
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_DEL_WR;
                    end
                end
                S_DEL_WR:
                begin
                    if (ptr_reg == req_idx)
                    begin
                        hold_x_reg <= rd_node.x;
                        hold_y_reg <= rd_node.y;
                    end
                    ptr_reg   <= ptr_inc;
                    state_reg <= S_DEL_RD;
                end
                S_MOV_RDLO:
                begin
                    state_reg <= (ptr_reg != '0) ? S_MOV_LO : S_MOV_RDHI;
                end
                S_MOV_LO:
                begin
                    lo_reg    <= rd_node.x + 16'd1;
                    state_reg <= S_MOV_RDHI;
                end
                S_MOV_RDHI:
                begin
                    state_reg <= (ptr_inc < count_reg) ? S_MOV_HI : S_MOV_WR;
                end
                S_MOV_HI:
                begin
                    hi_reg    <= rd_node.x - 16'd1;
                    state_reg <= S_MOV_WR;
                end
                S_MOV_WR:
                begin
                    result_reg <= pack_rsp(ST_DONE, req_reg.node_index, 6'(count_reg),
                                           mov_x, req_y, enable_reg);
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                S_PRE_WR0:
                begin
                    state_reg <= S_PRE_WR1;
                end
                S_PRE_WR1:
                begin
                    count_reg  <= CW'(2);
                    enable_reg <= 1'b1;
                    for (int m = 0; m < 4; m++)
                    begin
                        markers_reg[m] <= MARK_NONE;
                    end
                    result_reg <= pack_rsp(ST_DONE, '0, 6'd2, PRESET_X0, PRESET_Y, 1'b1);
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                // ram read data is registered: it is valid in the cycle after the address
                S_READ_RD:
                begin
                    state_reg <= S_READ_OUT;
                end
                S_READ_OUT:
                begin
                    result_reg <= pack_rsp(ST_DONE, 5'(ridx_reg), 6'(count_reg),
                                           rd_node.x, rd_node.y, enable_reg);
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done || busy)
        else $error("accepted request neither finished nor in progress");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_NODES))
        else $error("node count above table size");

    a_enable_count: assert property (@(posedge clk) disable iff (!rst_n)
        enable_reg |-> count_reg != '0)
        else $error("envelope enabled with empty table");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_DONE |-> result.out_x == '0 && result.out_y == '0)
        else $error("failed request reports node data");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_FULL |-> count_reg == CW'(MAX_NODES))
        else $error("table full reported below table size");

endmodule
